[hw/rtl/dpd_pkg.sv]
// Shared constants, codes and helper functions for the debug packet deframer.
// No dependencies; imported by debug_packet_deframer_unit.
`default_nettype none

package dpd_pkg;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 12;
	localparam int KIND_W   = 3;
	localparam int TDATA_W  = 32;

	// Packet buffer size on the consumer side; caps the kept payload length
	localparam int PACKET_BYTES = 4096;
	localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
	localparam int CAP_INT      = (PACKET_BYTES - 1 > COUNT_MAX) ? COUNT_MAX : PACKET_BYTES - 1;
	localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(CAP_INT);

	// Framing characters
	localparam logic [BYTE_W-1:0] CH_START = 8'h24;  // '$'
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;  // '#'
	localparam logic [BYTE_W-1:0] CH_BREAK = 8'h03;  // break request
	localparam logic [BYTE_W-1:0] CH_ACK   = 8'h2B;  // '+'
	localparam logic [BYTE_W-1:0] CH_NAK   = 8'h2D;  // '-'

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DATA    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BAD     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BREAK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

	// Hex digit decode: bit 4 set marks a byte that is not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] b);
		logic [4:0] n;
		if (b >= 8'h30 && b <= 8'h39) begin
			n = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			n = {1'b0, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			n = {1'b0, 4'(b - 8'h37)};
		end else begin
			n = 5'h10;
		end
		return n;
	endfunction

	// Expected checksum from the two digit bytes
	function automatic logic [BYTE_W-1:0] expected_sum(input logic [BYTE_W-1:0] hi_b,
		input logic [BYTE_W-1:0] lo_b);
		logic [4:0] hi;
		logic [4:0] lo;
		logic [BYTE_W-1:0] e;
		hi = hex_nibble(hi_b);
		lo = hex_nibble(lo_b);
		if (lo[4]) begin
			e = 8'hFF;
		end else begin
			e = {(hi[4] ? 4'hF : hi[3:0]), lo[3:0]};
		end
		return e;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/debug_packet_deframer_unit.sv]
// Debug packet deframer: input register, phase machine with checksum, result register.
// Depends on dpd_pkg for codes, widths and hex decoding.
//
// Usage:
//  - s_axis carries one received serial byte per beat in tdata[7:0].
//  - m_axis carries at most one result beat per input byte: tuser holds the kind
//    (payload byte, good frame, bad frame, break, restart), tdata the byte, length and sum.
//  - cfg writes the payload limit (max_payload); write only while the block is idle.
//  - An accepted byte passes from the input register through the phase machine to the result register.
//  - Throughput: one byte per cycle while the receiver takes each result; the phase machine
//    and 8-bit sum update combinationally between the input register and the result register.
//  - When the receiver stalls, the result register holds its beat and the input
//    register takes one more byte, then s_axis_tready drops until the result drains.
//  - Reset (arst_n low) empties both registers, returns to hunting for '$', clears
//    sum and count and sets max_payload to 4095.
//  - The kept length is capped at the smaller of max_payload and PACKET_BYTES-1.
`default_nettype none

module debug_packet_deframer_unit
	import dpd_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	// input stream
	input  wire                      s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire  [BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	output logic [TDATA_W-1:0]       m_axis_tdata,   // [7:0] data_byte, [19:8] payload_length,
	                                                 // [27:20] payload_sum, [31:28] zero
	output logic [KIND_W-1:0]        m_axis_tuser,   // [2:0] kind
	// configuration write
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [COUNT_W-1:0]       cfg_data        // max_payload
);

	// Phase codes
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_CS1  = 2'd2;
	localparam logic [1:0] PH_CS2  = 2'd3;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 fire;

	logic [1:0]           phase_q;
	logic [BYTE_W-1:0]    sum_q;
	logic [COUNT_W-1:0]   count_q;
	logic [BYTE_W-1:0]    digit_q;
	logic [COUNT_W-1:0]   max_payload_q;

	logic [BYTE_W-1:0]    out_data_q;
	logic [COUNT_W-1:0]   out_len_q;
	logic [BYTE_W-1:0]    out_sum_q;
	logic [KIND_W-1:0]    out_kind_q;

	logic [COUNT_W-1:0]   limit;
	logic                 res_valid;
	logic [KIND_W-1:0]    res_kind;
	logic [BYTE_W-1:0]    res_data;
	logic                 res_frame;
	logic [1:0]           phase_d;
	logic [BYTE_W-1:0]    sum_d;
	logic [COUNT_W-1:0]   count_d;
	logic [BYTE_W-1:0]    digit_d;

	// Process the held byte whenever the result register is free or draining
	assign fire          = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= COUNT_W'(COUNT_MAX);
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	assign limit = (max_payload_q > LIMIT_CAP) ? LIMIT_CAP : max_payload_q;

	// Phase machine and running checksum
	always_comb begin
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_data  = '0;
		res_frame = 1'b0;
		phase_d   = phase_q;
		sum_d     = sum_q;
		count_d   = count_q;
		digit_d   = digit_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == CH_START) begin
					phase_d = PH_DATA;
					sum_d   = '0;
					count_d = '0;
				end else if (byte_s1 == CH_BREAK) begin
					res_valid = 1'b1;
					res_kind  = KIND_BREAK;
				end
			end
			PH_DATA: begin
				if (byte_s1 == CH_HASH) begin
					phase_d = PH_CS1;
				end else if (byte_s1 == CH_START) begin
					sum_d     = '0;
					count_d   = '0;
					res_valid = 1'b1;
					res_kind  = KIND_RESTART;
				end else if (count_q < limit) begin
					sum_d     = sum_q + byte_s1;
					count_d   = count_q + 1'b1;
					res_valid = 1'b1;
					res_kind  = KIND_DATA;
					res_data  = byte_s1;
				end
			end
			PH_CS1: begin
				digit_d = byte_s1;
				phase_d = PH_CS2;
			end
			PH_CS2: begin
				phase_d   = PH_HUNT;
				res_valid = 1'b1;
				res_frame = 1'b1;
				res_kind  = (sum_q == expected_sum(digit_q, byte_s1)) ? KIND_GOOD : KIND_BAD;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			count_q <= '0;
			digit_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			digit_q <= digit_d;
		end
	end

	// Result register: load on fire, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire) begin
			m_axis_tvalid <= res_valid;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
			out_len_q  <= res_frame ? count_q : '0;
			out_sum_q  <= res_frame ? sum_q : '0;
		end
	end

	assign m_axis_tuser = out_kind_q;
	assign m_axis_tdata = {(TDATA_W - 2*BYTE_W - COUNT_W)'(0), out_sum_q, out_len_q, out_data_q};

	// Kept count never passes the cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT_CAP)
		else $error("kept count above cap");

	// A verdict always returns to hunting
	a_verdict_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_CS2 |=> phase_q == PH_HUNT && m_axis_tvalid)
		else $error("verdict did not return to hunt");

	// A payload beat advances the count by one
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && res_kind == KIND_DATA |=> count_q == $past(count_q) + 1'b1)
		else $error("payload beat without count step");

	// Non-payload results carry a zero data byte
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[BYTE_W-1:0] == '0)
		else $error("data byte set on non-payload result");

endmodule

`default_nettype wire
